// ----- src/piecewise_linear_curve_eval_assert.svh -----
// assertion macros for the piecewise linear curve evaluator
`ifndef PIECEWISE_LINEAR_CURVE_EVAL_ASSERT_SVH
`define PIECEWISE_LINEAR_CURVE_EVAL_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication, checked out of reset
`define PLCE_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("plce check failed");
// next-cycle implication, checked out of reset
`define PLCE_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("plce check failed");
`else
`define PLCE_ASSERT_IMP(label, ante, cons)
`define PLCE_ASSERT_NXT(label, ante, cons)
`endif
`endif

// ----- src/plce_pkg.sv -----
// shared types and constants of the curve evaluator
package plce_pkg;

  localparam int KEY_W     = 32;
  localparam int VAL_W     = 32;
  localparam int IDX_W     = 3;
  localparam int CFG_W     = 4;
  localparam int PROD_W    = 2 * VAL_W;
  localparam int IN_DATA_W = 104;
  localparam int OUT_DATA_W = 32;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_EVAL  = 1'b1;

  typedef enum logic [2:0] {
    RES_HOLD,
    RES_BELOW,
    RES_TAIL,
    RES_LEFT,
    RES_DIV
  } res_sel_t;

  typedef struct packed {
    logic     wr_en;
    logic     q_load;
    logic     scan_clr;
    logic     rd_issue;
    logic     scan_adv;
    logic     pair_load;
    logic     mul_go;
    logic     div_start;
    res_sel_t res_sel;
    logic     out_load;
  } plce_cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic hit_pair;
    logic dist_zero;
    logic hit_tail;
    logic last;
    logic div_busy;
    logic div_done;
    logic out_full;
  } plce_stat_t;

endpackage

// ----- src/piecewise_linear_curve_eval.sv -----
// top level of the piecewise linear curve evaluator
//
//  channel  direction  handshake              payload
//  in_      slave      in_tvalid/in_tready    tdata: index, key, value, query; tuser: mode
//  out_     master     out_tvalid/out_tready  tdata: curve_value; tuser: below_table
//  cfg_     slave      cfg_valid/cfg_ready    cfg_data: point_count
//
// a write request is stored as it is taken; an evaluate request reads and checks each slot
// scanned, then when it interpolates multiplies, starts the divider and waits for the quotient
// its time is set by the read-then-check memory scan and the serial divider
// reset is synchronous and active low; table contents are undefined until written
// a finished result waits in the output register; the next request is taken meanwhile
`include "piecewise_linear_curve_eval_assert.svh"

module piecewise_linear_curve_eval #(
  parameter int MAX_POINTS = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // in_tdata from bit 0: point_index[2:0], point_key[31:0], point_value[31:0],
  // query[31:0], zero fill
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [plce_pkg::IN_DATA_W-1:0]      in_tdata,
  input  logic                                in_tuser,   // mode
  // out_tdata from bit 0: curve_value[31:0]
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [plce_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic                                out_tuser,  // below_table
  // point_count register
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [plce_pkg::CFG_W-1:0]          cfg_data
);

  localparam int KEY_LO = plce_pkg::IDX_W;
  localparam int VAL_LO = KEY_LO + plce_pkg::KEY_W;
  localparam int QRY_LO = VAL_LO + plce_pkg::VAL_W;

  plce_pkg::plce_cmd_t  cmd;
  plce_pkg::plce_stat_t stat;

  logic [plce_pkg::IDX_W-1:0]        point_index;
  logic signed [plce_pkg::KEY_W-1:0] point_key;
  logic signed [plce_pkg::VAL_W-1:0] point_value;
  logic signed [plce_pkg::KEY_W-1:0] query;
  logic [plce_pkg::VAL_W-1:0]        curve_value;

  // unpack the request fields
  assign point_index = in_tdata[KEY_LO-1:0];
  assign point_key   = in_tdata[VAL_LO-1:KEY_LO];
  assign point_value = in_tdata[QRY_LO-1:VAL_LO];
  assign query       = in_tdata[QRY_LO+plce_pkg::KEY_W-1:QRY_LO];

  // the count register takes a write in any cycle
  assign cfg_ready = 1'b1;

  plce_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_mode   (in_tuser),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  plce_dp #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .cfg_valid       (cfg_valid),
    .cfg_data        (cfg_data),
    .in_point_index  (point_index),
    .in_point_key    (point_key),
    .in_point_value  (point_value),
    .in_query        (query),
    .out_tready      (out_tready),
    .out_tvalid      (out_tvalid),
    .out_curve_value (curve_value),
    .out_below_table (out_tuser)
  );

  assign out_tdata = curve_value;

  // no request is taken while the divider is still stepping
  `PLCE_ASSERT_IMP(a_idle_div_quiet, in_tready, !stat.div_busy)
  // a result is loaded only when the output register is free or draining
  `PLCE_ASSERT_IMP(a_out_load_free, cmd.out_load, !out_tvalid || out_tready)
  // an evaluate request blocks intake on the next cycle
  `PLCE_ASSERT_NXT(a_eval_busy, in_tvalid && in_tready && (in_tuser == plce_pkg::MODE_EVAL),
                   !in_tready)

endmodule

// ----- src/plce_div.sv -----
// iterative unsigned 64 by 32 divider, one quotient bit per cycle
module plce_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [plce_pkg::PROD_W-1:0]   dividend,
  input  logic [plce_pkg::VAL_W-1:0]    divisor,
  output logic                          busy,
  output logic                          done,
  output logic [plce_pkg::VAL_W-1:0]    quotient
);

  localparam int QW      = plce_pkg::VAL_W;
  localparam int SW      = $clog2(QW);
  localparam int PROD_HI = plce_pkg::PROD_W - 1;

  logic          busy_r;
  logic          done_r;
  logic [SW-1:0] step_r;
  logic [QW-1:0] rem_r;
  logic [QW-1:0] lo_r;
  logic [QW-1:0] div_r;
  logic [QW:0]   trial;
  logic [QW:0]   diff;
  logic          fits;

  // quotient is known to fit 32 bits, so the upper half starts below the divisor
  assign trial = {rem_r, lo_r[QW-1]};
  assign diff  = trial - {1'b0, div_r};
  assign fits  = (trial >= {1'b0, div_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + SW'(1);
        if (step_r == SW'(QW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend[PROD_HI:QW];
      lo_r  <= dividend[QW-1:0];
      div_r <= divisor;
    end else if (busy_r) begin
      rem_r <= fits ? diff[QW-1:0] : trial[QW-1:0];
      lo_r  <= {lo_r[QW-2:0], fits};
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = lo_r;

endmodule

// ----- src/plce_ctrl.sv -----
// controller state machine: request intake, table scan, multiply, divide, result hand-off
module plce_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_mode,
  output logic                  in_tready,
  input  plce_pkg::plce_stat_t  stat,
  output plce_pkg::plce_cmd_t   cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RD   = 3'd1;
  localparam logic [2:0] ST_CHK  = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_DVS  = 3'd4;
  localparam logic [2:0] ST_DVW  = 3'd5;
  localparam logic [2:0] ST_FIN  = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       accept;

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    cmd       = '0;
    cmd.res_sel = plce_pkg::RES_HOLD;
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && (in_mode == plce_pkg::MODE_WRITE)) begin
          cmd.wr_en = 1'b1;
        end else if (accept) begin
          cmd.q_load   = 1'b1;
          cmd.scan_clr = 1'b1;
          if (stat.cnt_zero) begin
            cmd.res_sel = plce_pkg::RES_BELOW;
            state_nxt   = ST_FIN;
          end else begin
            state_nxt = ST_RD;
          end
        end
      end
      ST_RD: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = ST_CHK;
      end
      ST_CHK: begin
        if (stat.hit_pair && stat.dist_zero) begin
          cmd.res_sel = plce_pkg::RES_LEFT;
          state_nxt   = ST_FIN;
        end else if (stat.hit_pair) begin
          cmd.pair_load = 1'b1;
          state_nxt     = ST_MUL;
        end else if (stat.hit_tail) begin
          cmd.res_sel = plce_pkg::RES_TAIL;
          state_nxt   = ST_FIN;
        end else if (stat.last) begin
          cmd.res_sel = plce_pkg::RES_BELOW;
          state_nxt   = ST_FIN;
        end else begin
          cmd.scan_adv = 1'b1;
          state_nxt    = ST_RD;
        end
      end
      ST_MUL: begin
        cmd.mul_go = 1'b1;
        state_nxt  = ST_DVS;
      end
      ST_DVS: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_DVW;
      end
      ST_DVW: begin
        if (stat.div_done) begin
          cmd.res_sel = plce_pkg::RES_DIV;
          state_nxt   = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!stat.out_full) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- src/plce_dp.sv -----
// datapath: breakpoint memory, scan registers, multiplier, divider, result registers
module plce_dp #(
  parameter int MAX_POINTS = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  plce_pkg::plce_cmd_t               cmd,
  output plce_pkg::plce_stat_t              stat,
  input  logic                              cfg_valid,
  input  logic [plce_pkg::CFG_W-1:0]        cfg_data,
  input  logic [plce_pkg::IDX_W-1:0]        in_point_index,
  input  logic signed [plce_pkg::KEY_W-1:0] in_point_key,
  input  logic signed [plce_pkg::VAL_W-1:0] in_point_value,
  input  logic signed [plce_pkg::KEY_W-1:0] in_query,
  input  logic                              out_tready,
  output logic                              out_tvalid,
  output logic [plce_pkg::VAL_W-1:0]        out_curve_value,
  output logic                              out_below_table
);

  localparam int KW    = plce_pkg::KEY_W;
  localparam int VW    = plce_pkg::VAL_W;
  localparam int PW    = plce_pkg::PROD_W;
  localparam int AW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW    = $clog2(MAX_POINTS + 1);
  localparam int WORD_W = KW + VW;

  // breakpoint memory, key in the upper half
  logic [WORD_W-1:0] pt_mem_r [MAX_POINTS];
  logic [WORD_W-1:0] rd_word_r;

  logic [plce_pkg::CFG_W-1:0] pcount_r;
  logic [CW-1:0]              n_eff;
  logic [CW-1:0]              j_r;
  logic                       wr_ok;

  logic signed [KW-1:0] q_r;
  logic signed [KW-1:0] prev_key_r;
  logic signed [VW-1:0] prev_val_r;
  logic signed [KW-1:0] cur_key;
  logic signed [VW-1:0] cur_val;

  logic signed [KW:0] dq_full;
  logic signed [KW:0] dist_full;
  logic signed [VW:0] chg_full;
  logic signed [VW:0] chg_abs;

  logic [KW-1:0]             dq_r;
  logic [KW-1:0]             dist_r;
  logic [VW-1:0]             mag_r;
  logic                      neg_r;
  logic signed [VW-1:0]      v0_r;
  logic [plce_pkg::PROD_W-1:0] prod_r;

  logic          div_busy;
  logic          div_done;
  logic [VW-1:0] quo;
  logic [VW+1:0] sum;
  logic [VW-1:0] sat_val;

  logic [VW-1:0] res_val_r;
  logic          res_below_r;
  logic          out_tvalid_r;
  logic [VW-1:0] out_val_r;
  logic          out_below_r;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pcount_r <= '0;
    end else if (cfg_valid) begin
      pcount_r <= cfg_data;
    end
  end

  assign n_eff = (int'(pcount_r) > MAX_POINTS) ? CW'(MAX_POINTS) : CW'(pcount_r);

  // table writes, slots past the table size are dropped
  assign wr_ok = cmd.wr_en && (int'(in_point_index) < MAX_POINTS);

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      pt_mem_r[AW'(in_point_index)] <= {in_point_key, in_point_value};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_issue) begin
      rd_word_r <= pt_mem_r[j_r[AW-1:0]];
    end
  end

  assign cur_key = rd_word_r[WORD_W-1:VW];
  assign cur_val = rd_word_r[VW-1:0];

  // scan position and the previous slot
  always_ff @(posedge clk) begin
    if (cmd.q_load) begin
      q_r <= in_query;
    end
    if (cmd.scan_clr) begin
      j_r <= '0;
    end else if (cmd.scan_adv) begin
      j_r        <= j_r + CW'(1);
      prev_key_r <= cur_key;
      prev_val_r <= cur_val;
    end
  end

  assign dq_full   = {q_r[KW-1], q_r} - {prev_key_r[KW-1], prev_key_r};
  assign dist_full = {cur_key[KW-1], cur_key} - {prev_key_r[KW-1], prev_key_r};
  assign chg_full  = {cur_val[VW-1], cur_val} - {prev_val_r[VW-1], prev_val_r};
  assign chg_abs   = chg_full[VW] ? -chg_full : chg_full;

  assign stat.cnt_zero  = (n_eff == '0);
  assign stat.hit_pair  = (j_r != '0) && (prev_key_r <= q_r) && (cur_key >= q_r);
  assign stat.dist_zero = (cur_key == prev_key_r);
  assign stat.last      = (j_r == (n_eff - CW'(1)));
  assign stat.hit_tail  = stat.last && (cur_key <= q_r);
  assign stat.div_busy  = div_busy;
  assign stat.div_done  = div_done;
  assign stat.out_full  = out_tvalid_r && !out_tready;

  // interpolation operands, all magnitudes below 2^32
  always_ff @(posedge clk) begin
    if (cmd.pair_load) begin
      dq_r   <= dq_full[KW-1:0];
      dist_r <= dist_full[KW-1:0];
      mag_r  <= chg_abs[VW-1:0];
      neg_r  <= chg_full[VW];
      v0_r   <= prev_val_r;
    end
    if (cmd.mul_go) begin
      prod_r <= PW'(dq_r) * PW'(mag_r);
    end
  end

  plce_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (prod_r),
    .divisor  (dist_r),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (quo)
  );

  assign sum = neg_r ? ({{2{v0_r[VW-1]}}, v0_r} - {2'b00, quo})
                     : ({{2{v0_r[VW-1]}}, v0_r} + {2'b00, quo});

  always_comb begin
    if (!sum[VW+1] && (sum[VW] || sum[VW-1])) begin
      sat_val = {1'b0, {(VW-1){1'b1}}};
    end else if (sum[VW+1] && !(sum[VW] && sum[VW-1])) begin
      sat_val = {1'b1, {(VW-1){1'b0}}};
    end else begin
      sat_val = sum[VW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.res_sel)
      plce_pkg::RES_BELOW: begin
        res_val_r   <= '0;
        res_below_r <= 1'b1;
      end
      plce_pkg::RES_TAIL: begin
        res_val_r   <= cur_val;
        res_below_r <= 1'b0;
      end
      plce_pkg::RES_LEFT: begin
        res_val_r   <= prev_val_r;
        res_below_r <= 1'b0;
      end
      plce_pkg::RES_DIV: begin
        res_val_r   <= sat_val;
        res_below_r <= 1'b0;
      end
      default: begin
        res_val_r   <= res_val_r;
        res_below_r <= res_below_r;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_val_r   <= res_val_r;
      out_below_r <= res_below_r;
    end
  end

  assign out_tvalid      = out_tvalid_r;
  assign out_curve_value = out_val_r;
  assign out_below_table = out_below_r;

endmodule

// ----- sim/plce_curve_checker.sv -----
// result predictor and scoreboard for the piecewise linear curve evaluator
module plce_curve_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [plce_pkg::IN_DATA_W-1:0]  in_tdata,   // index, key, value, query, zero fill
  input  logic                            in_tuser,   // mode
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [plce_pkg::OUT_DATA_W-1:0] out_tdata,  // curve_value
  input  logic                            out_tuser,  // below_table
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [plce_pkg::CFG_W-1:0]      cfg_data,   // point_count
  output int                              fail_count,
  output int                              pending
);

  localparam int     KEY_W     = plce_pkg::KEY_W;
  localparam int     VAL_W     = plce_pkg::VAL_W;
  localparam int     IDX_W     = plce_pkg::IDX_W;
  localparam int     CFG_W     = plce_pkg::CFG_W;
  localparam int     TBL_DEPTH = 8;
  localparam int     EXP_DEPTH = 8;
  localparam int     KEY_LSB   = IDX_W;
  localparam int     VAL_LSB   = IDX_W + KEY_W;
  localparam int     QRY_LSB   = IDX_W + KEY_W + VAL_W;
  localparam longint CURVE_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam longint CURVE_MIN = -64'sh0000_0000_8000_0000;

  typedef struct packed {
    logic             below_table;
    logic [VAL_W-1:0] curve_value;
  } curve_result_t;

  logic signed [KEY_W-1:0] knot_key [TBL_DEPTH];
  logic signed [VAL_W-1:0] knot_val [TBL_DEPTH];
  logic [CFG_W-1:0]        knots_in_use;
  // expected results in request order, a small ring
  curve_result_t           expect_mem [EXP_DEPTH];
  int                      expect_head;
  int                      expect_count;

  // first slot with key <= query and next key >= query wins; else the last key if <= query
  function automatic curve_result_t eval_curve(input logic signed [KEY_W-1:0] q);
    curve_result_t     r;
    int                n;
    longint            k0, v0, k1, v1, chg, lin;
    longint unsigned   span, offset, mag, quo;
    r.below_table = 1'b1;
    r.curve_value = '0;
    n = (knots_in_use > TBL_DEPTH) ? TBL_DEPTH : int'(knots_in_use);
    for (int i = 0; i < n && r.below_table; i++) begin
      if (knot_key[i] <= q) begin
        if (i + 1 < n) begin
          if (knot_key[i+1] >= q) begin
            k0 = knot_key[i];
            v0 = knot_val[i];
            k1 = knot_key[i+1];
            v1 = knot_val[i+1];
            span = k1 - k0;
            offset = q - k0;
            chg = v1 - v0;
            if (span == 0) begin
              lin = v0;
            end else begin
              mag = (chg < 0) ? -chg : chg;
              quo = (offset * mag) / span;
              lin = (chg < 0) ? v0 - longint'(quo) : v0 + longint'(quo);
            end
            if (lin > CURVE_MAX) lin = CURVE_MAX;
            if (lin < CURVE_MIN) lin = CURVE_MIN;
            r.curve_value = lin[VAL_W-1:0];
            r.below_table = 1'b0;
          end
        end else begin
          r.curve_value = knot_val[i];
          r.below_table = 1'b0;
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    curve_result_t    want;
    logic [IDX_W-1:0] slot;
    if (!rst_n) begin
      knots_in_use = '0;
      expect_head = 0;
      expect_count = 0;
      fail_count = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expect_count == 0) begin
          $error("unexpected result: curve_value %h below_table %b", out_tdata, out_tuser);
          fail_count++;
        end else begin
          want = expect_mem[expect_head];
          expect_head = (expect_head + 1) % EXP_DEPTH;
          expect_count--;
          if (out_tdata[VAL_W-1:0] !== want.curve_value) begin
            $error("curve_value: expected %h, got %h", want.curve_value, out_tdata[VAL_W-1:0]);
            fail_count++;
          end
          if (out_tuser !== want.below_table) begin
            $error("below_table: expected %b, got %b", want.below_table, out_tuser);
            fail_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready) knots_in_use = cfg_data;
      if (in_tvalid && in_tready) begin
        if (in_tuser == plce_pkg::MODE_WRITE) begin
          slot = in_tdata[IDX_W-1:0];
          knot_key[slot] = in_tdata[KEY_LSB +: KEY_W];
          knot_val[slot] = in_tdata[VAL_LSB +: VAL_W];
        end else if (expect_count == EXP_DEPTH) begin
          $error("too many results outstanding: expected at most %0d", EXP_DEPTH);
          fail_count++;
        end else begin
          expect_mem[(expect_head + expect_count) % EXP_DEPTH] =
            eval_curve(in_tdata[QRY_LSB +: KEY_W]);
          expect_count++;
        end
      end
    end
    pending = expect_count;
  end

endmodule

// ----- sim/tb_piecewise_linear_curve_eval.sv -----
// testbench top for the piecewise linear curve evaluator: stimulus, stalls and verdict
module tb_piecewise_linear_curve_eval;

  localparam int IN_DATA_W       = plce_pkg::IN_DATA_W;
  localparam int OUT_DATA_W      = plce_pkg::OUT_DATA_W;
  localparam int KEY_W           = plce_pkg::KEY_W;
  localparam int VAL_W           = plce_pkg::VAL_W;
  localparam int IDX_W           = plce_pkg::IDX_W;
  localparam int CFG_W           = plce_pkg::CFG_W;
  localparam int TBL_DEPTH       = 8;
  localparam int TARGET_REQUESTS = 550;
  // idle time after the last result is back; used before config writes and at the end
  localparam int SETTLE_CYCLES   = 64;
  // cycles with no handshake on any channel before the run is declared hung
  localparam int STALL_LIMIT     = 4000;

  typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_SPARSE, RX_HOLD} rx_mode_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;   // index, key, value, query, zero fill
  logic                  in_tuser;   // mode
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;  // curve_value
  logic                  out_tuser;  // below_table
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_W-1:0]      cfg_data;   // point_count

  int fail_count;
  int pending;

  // sender burst state
  int tx_gap_max;
  int tx_burst_left;
  int requests_sent;

  // copy of the keys the table should hold, only used to aim queries
  logic signed [KEY_W-1:0] shadow_key [TBL_DEPTH];
  int                      shadow_used;

  // receiver stall pattern state
  rx_mode_t rx_mode = RX_OPEN;
  int       rx_left = 0;
  int       idle_cycles = 0;

  always #4 clk = ~clk;

  piecewise_linear_curve_eval #(.MAX_POINTS(TBL_DEPTH)) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  // predicts every evaluate request and compares the results as they leave
  plce_curve_checker curve_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // receiver: stretches of random length, each with its own stall pattern
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
      rx_left <= $urandom_range(20, 150);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_OPEN:   out_tready <= 1'b1;                      // no stalls at all
      RX_RANDOM: out_tready <= 1'($urandom_range(0, 1));  // coin flip every cycle
      RX_SPARSE: out_tready <= (rx_left % 8 == 0);        // ready on every eighth count
      default:   out_tready <= (rx_left < 5);             // long stall, then a short window
    endcase
  end

  // watchdog: any handshake counts as progress
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("tb_piecewise_linear_curve_eval failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // one request on the input channel; called and returns at a falling edge
  task automatic send_request(input logic mode, input logic [IDX_W-1:0] slot,
                              input logic [KEY_W-1:0] key, input logic [VAL_W-1:0] val,
                              input logic [KEY_W-1:0] qry);
    logic [IN_DATA_W-1:0] word;
    int                   gap;
    // a new burst starts after a random gap
    if (tx_burst_left == 0) begin
      gap = $urandom_range(0, tx_gap_max);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      tx_burst_left = $urandom_range(1, 12);
    end
    tx_burst_left--;
    word = '0;
    word[IDX_W-1:0] = slot;
    word[IDX_W +: KEY_W] = key;
    word[IDX_W + KEY_W +: VAL_W] = val;
    word[IDX_W + KEY_W + VAL_W +: KEY_W] = qry;
    in_tvalid <= 1'b1;
    in_tuser <= mode;
    in_tdata <= word;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    requests_sent++;
    if (mode == plce_pkg::MODE_WRITE) shadow_key[slot] = key;
  endtask

  // unused fields carry random bits so every field bit toggles
  task automatic write_point(input logic [IDX_W-1:0] slot, input logic [KEY_W-1:0] key,
                             input logic [VAL_W-1:0] val);
    send_request(plce_pkg::MODE_WRITE, slot, key, val, $urandom);
  endtask

  task automatic eval_at(input logic [KEY_W-1:0] qry);
    send_request(plce_pkg::MODE_EVAL, IDX_W'($urandom), $urandom, $urandom, qry);
  endtask

  // sender holds off until every result is back, then lets the block settle
  task automatic drain_results;
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // point_count is only written with the block idle
  task automatic write_point_count(input logic [CFG_W-1:0] cnt);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data <= cnt;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    shadow_used = (cnt > TBL_DEPTH) ? TBL_DEPTH : int'(cnt);
  endtask

  // fresh ascending table: wide spread, tight cluster with repeats, or full range
  task automatic load_sorted_table;
    longint           k;
    longint           hop;
    int unsigned      step_max;
    logic [VAL_W-1:0] val;
    case ($urandom_range(0, 2))
      0: begin
        k = $urandom_range(0, 32'h7FFF_FFFF);
        k = k - 64'sd2147483648;
        step_max = 32'h2000_0000;
      end
      1: begin
        k = $signed($urandom);
        step_max = 32'h0003_0000;   // zero steps give equal adjacent keys
      end
      default: begin
        k = -64'sd2147483648;
        step_max = 32'h2492_4924;   // about a seventh of the full key range
      end
    endcase
    for (int s = 0; s < TBL_DEPTH; s++) begin
      if ($urandom_range(0, 1)) val = $urandom;
      else val = $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
      write_point(IDX_W'(s), k[KEY_W-1:0], val);
      hop = $urandom_range(0, step_max);
      k = k + hop;
      if (k > 64'sd2147483647) k = 64'sd2147483647;
    end
  endtask

  // query aimed at the table: on a key, between keys, next to a key, below it, or anywhere
  task automatic eval_shaped;
    longint          q, lo, hi, hop;
    longint unsigned rnd;
    int              s, pick;
    logic [31:0]     raw;
    pick = $urandom_range(0, 99);
    s = (shadow_used > 0) ? $urandom_range(0, shadow_used - 1) : 0;
    lo = shadow_key[s];
    hi = (s + 1 < TBL_DEPTH) ? shadow_key[s+1] : 64'sd2147483647;
    if (pick < 25) begin
      q = lo;
    end else if (pick < 60) begin
      if (hi > lo) begin
        rnd = {$urandom, $urandom};
        q = lo + longint'(rnd % (hi - lo + 1));
      end else begin
        q = lo;
      end
    end else if (pick < 75) begin
      hop = $urandom_range(0, 2);
      q = lo + hop - 1;
    end else if (pick < 85) begin
      hop = $urandom_range(1, 32'h0002_0000);
      q = shadow_key[0];
      q = q - hop;
    end else if (pick < 95) begin
      raw = $urandom;
      q = $signed(raw);
    end else begin
      q = pick[0] ? 64'sd2147483647 : -64'sd2147483648;
    end
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    if (q < -64'sd2147483648) q = -64'sd2147483648;
    eval_at(q[KEY_W-1:0]);
  endtask

  initial begin
    int cnt_pick;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= plce_pkg::MODE_WRITE;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    rst_n <= 1'b0;
    tx_gap_max = 0;
    tx_burst_left = 0;
    requests_sent = 0;
    shadow_used = 0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty table straight out of reset: value 0 with the below flag
    eval_at(32'h0000_0000);
    eval_at(32'h7FFF_FFFF);

    // every slot written before any is put in use; equal keys at the bottom,
    // extreme keys and values, a falling segment
    write_point(0, 32'h8000_0000, 32'h7FFF_FFFF);
    write_point(1, 32'h8000_0000, 32'h8000_0000);
    write_point(2, 32'hFFFF_0000, 32'h0000_0005);
    write_point(3, 32'h0000_0000, 32'h0001_2345);
    write_point(4, 32'h0001_0000, 32'hFFFD_0000);
    write_point(5, 32'h0002_8000, 32'h7FFF_FFFF);
    write_point(6, 32'h7FFF_0000, 32'h8000_0000);
    write_point(7, 32'h7FFF_FFFF, 32'h0000_0001);
    write_point_count(4'd8);
    eval_at(32'h8000_0000);   // equal adjacent keys: left value, no divide
    eval_at(32'h8000_0001);   // widest segment, rising from the minimum value
    eval_at(32'hFFFF_8000);   // midpoint of a rising segment
    eval_at(32'h0001_4000);   // rising segment up to the maximum value
    eval_at(32'h7FFF_8000);
    eval_at(32'h7FFF_FFFF);   // top of the last segment
    // count above the table depth is clamped
    write_point_count(4'd15);
    eval_at(32'h0002_0000);
    // query past the last key in use returns the last value
    write_point_count(4'd1);
    eval_at(32'h1234_5678);
    write_point_count(4'd3);
    eval_at(32'h4000_0000);
    // single point, first above the query with nothing at or below it, then at the query
    write_point(0, 32'h0000_0000, 32'h0000_0007);
    write_point_count(4'd1);
    eval_at(32'hFFFF_FFFF);
    eval_at(32'h0000_0000);

    // random phases: new count, new sender pacing, usually a fresh sorted table,
    // then aimed queries with stray writes that may break the ordering
    while (requests_sent < TARGET_REQUESTS) begin
      cnt_pick = $urandom_range(0, 5);
      case (cnt_pick)
        0:       write_point_count(4'd0);
        1:       write_point_count(4'd8);
        2:       write_point_count(4'd15);
        3:       write_point_count(4'd1);
        default: write_point_count(CFG_W'($urandom_range(0, 15)));
      endcase
      case ($urandom_range(0, 2))
        0:       tx_gap_max = 0;    // back-to-back requests
        1:       tx_gap_max = 3;
        default: tx_gap_max = 20;
      endcase
      tx_burst_left = 0;
      if ($urandom_range(0, 3) != 0) load_sorted_table();
      repeat ($urandom_range(15, 45)) begin
        if ($urandom_range(0, 9) == 0) write_point(IDX_W'($urandom), $urandom, $urandom);
        else eval_shaped();
        // occasional pause mid-phase until all results are back
        if ($urandom_range(0, 149) == 0) drain_results();
      end
    end

    drain_results();
    if (fail_count == 0 && pending == 0) begin
      $display("tb_piecewise_linear_curve_eval passed");
    end else begin
      $display("tb_piecewise_linear_curve_eval failed");
    end
    $finish;
  end

endmodule
